// File: rtl/core/tpid_pkg.sv
// ============================================================================
// tpid_pkg
// Shared types and constants of the timestamped PID controller: command and
// status bundles between controller and datapath, operand selects and codes.
// ============================================================================
package tpid_pkg;

  localparam int GAIN_BITS     = 32;
  localparam int ACC_BITS      = 64;
  localparam int Q_FRAC        = 16;
  localparam int DIGIT_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_P     = 2'd0,
    MSEL_INC   = 2'd1,
    MSEL_ITERM = 2'd2,
    MSEL_DTERM = 2'd3
  } msel_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD_MUL = 2'd1,
    ACC_ADD_MUL  = 2'd2,
    ACC_ADD_DIV  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    mul_start;
    msel_t   mul_sel;
    acc_op_t acc_op;
    logic    isum_add;
    logic    div_start;
    logic    set_status;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic held_valid;
    logic gap_zero;
    logic gain_i_nz;
    logic gain_d_nz;
    logic diff_nz;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/tpid_in_if.sv
// ============================================================================
// tpid_in_if
// Input channel of the PID controller: one beat carries an op code, a sample
// and its timestamp.
// ============================================================================
interface tpid_in_if #(
  parameter int SAMPLE_BITS = 32,
  parameter int TIME_BITS   = 32
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [TIME_BITS-1:0]   stamp;

  modport source (output valid, output op, output sample, output stamp, input ready);
  modport sink   (input valid, input op, input sample, input stamp, output ready);
endinterface

// File: rtl/core/tpid_out_if.sv
// ============================================================================
// tpid_out_if
// Result channel of the PID controller: one beat carries the drive value and
// a status flag.
// ============================================================================
interface tpid_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] drive;
  logic                          status;

  modport source (output valid, output drive, output status, input ready);
  modport sink   (input valid, input drive, input status, output ready);
endinterface

// File: rtl/core/timestamped_pid_controller_core.sv
// ============================================================================
// timestamped_pid_controller_core
// Event-driven PID controller with a trapezoidal integral over tick gaps.
// ============================================================================
// Usage:
//   in_ch carries one beat per event: op selects a new sample or a clear of
//   the integral accumulator and held sample. A sample beat yields one beat
//   on out_ch (saturated drive and a status flag); a clear beat yields none.
//   The gains are written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequence:
//   One item is processed at a time; a clear is completed while idle. A
//   sample runs the proportional multiply. With a held sample and a nonzero
//   gap, the integral increment and integral term multiplies follow when the
//   integral gain is nonzero, and the derivative numerator multiply and its
//   divide on the one-bit-per-cycle divider when the derivative gain is
//   nonzero. All multiplies use the shared multiplier.
// Reset and stall:
//   Reset clears the gains, the held sample and the integral accumulator. A result
//   waits in the output register while out_ch.ready is low; the next input
//   beat is still taken, and its result waits until the register frees.
// ============================================================================
module timestamped_pid_controller_core
  import tpid_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  tpid_in_if.sink                  in_ch,
  tpid_out_if.source               out_ch
);

  cmd_t cmd;
  sts_t sts;

  tpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpid_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_ch.sample),
    .in_stamp   (in_ch.stamp),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_drive  (out_ch.drive),
    .out_status (out_ch.status)
  );

endmodule

// File: rtl/core/tpid_mul.sv
// ============================================================================
// tpid_mul
// Shared sign-magnitude multiplier, one 16-bit digit of B per cycle, followed
// by a sign stage and a fixed-point shift with 64-bit saturation.
// ============================================================================
module tpid_mul
  import tpid_pkg::*;
#(
  parameter int B_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ACC_BITS-1:0]        a_mag,
  input  logic [B_BITS-1:0]          b_mag,
  input  logic                       neg,
  input  logic                       frac,
  output logic                       done,
  output logic signed [ACC_BITS-1:0] res
);

  localparam int DIGITS = B_BITS / DIGIT_BITS;
  localparam int PW     = ACC_BITS + B_BITS;
  localparam int CW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [ACC_BITS-1:0]            a_r;
  logic [PW-1:0]                  prod_r;
  logic                           neg_r;
  logic                           frac_r;
  logic                           run_r;
  logic                           ng_r;
  logic                           st_r;
  logic                           done_r;
  logic [CW-1:0]                  cnt_r;
  logic signed [PW:0]             sp_r;
  logic signed [ACC_BITS-1:0]     res_r;

  logic [ACC_BITS+DIGIT_BITS-1:0] partial;
  logic [ACC_BITS+DIGIT_BITS-1:0] step_sum;
  logic [PW-1:0]                  prod_nxt;
  logic [PW:0]                    sp_nxt;
  logic signed [PW:0]             shifted;
  logic [PW-ACC_BITS+1:0]         top_bits;
  logic signed [ACC_BITS-1:0]     res_nxt;

  // The running sum sits in the upper bits while B's digits shift out below.
  always_comb begin
    partial  = a_r * prod_r[DIGIT_BITS-1:0];
    step_sum = {{DIGIT_BITS{1'b0}}, prod_r[PW-1:B_BITS]} + partial;
    prod_nxt = {step_sum, prod_r[B_BITS-1:DIGIT_BITS]};
    sp_nxt   = neg_r ? (~{1'b0, prod_r} + 1'b1) : {1'b0, prod_r};
    shifted  = frac_r ? (sp_r >>> Q_FRAC) : (sp_r >>> 1);
    top_bits = shifted[PW:ACC_BITS-1];
    if (&top_bits || ~|top_bits) begin
      res_nxt = shifted[ACC_BITS-1:0];
    end else begin
      res_nxt = sp_r[PW] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ng_r   <= 1'b0;
      st_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= st_r;
      st_r   <= ng_r;
      ng_r   <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIGITS - 1)) begin
          run_r <= 1'b0;
          ng_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a_mag;
      prod_r <= {{ACC_BITS{1'b0}}, b_mag};
      neg_r  <= neg;
      frac_r <= frac;
    end else if (run_r) begin
      prod_r <= prod_nxt;
    end
    if (ng_r) begin
      sp_r <= sp_nxt;
    end
    if (st_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: rtl/core/tpid_div.sv
// ============================================================================
// tpid_div
// Restoring divider, one quotient bit per cycle: signed 64-bit numerator by
// an unsigned tick gap, quotient truncated toward zero.
// ============================================================================
module tpid_div
  import tpid_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [ACC_BITS-1:0] num,
  input  logic [TIME_BITS-1:0]       den,
  output logic                       done,
  output logic signed [ACC_BITS-1:0] res
);

  localparam int CW = $clog2(ACC_BITS);

  logic                       run_r;
  logic                       fin_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic [ACC_BITS-1:0]        q_r;
  logic [TIME_BITS-1:0]       rem_r;
  logic [TIME_BITS-1:0]       den_r;
  logic                       neg_r;
  logic signed [ACC_BITS-1:0] res_r;

  logic [TIME_BITS:0]         trial;
  logic [TIME_BITS:0]         diff;
  logic                       qbit;

  always_comb begin
    trial = {rem_r, q_r[ACC_BITS-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ACC_BITS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[ACC_BITS-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[ACC_BITS-1];
    end else if (run_r) begin
      q_r   <= {q_r[ACC_BITS-2:0], qbit};
      rem_r <= qbit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    end
    if (fin_r) begin
      res_r <= neg_r ? (~q_r + 1'b1) : q_r;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: rtl/core/tpid_dp.sv
// ============================================================================
// tpid_dp
// Datapath of the PID controller: gain registers, held sample state, the
// integral accumulator, the drive accumulator, the shared multiplier and
// divider, and the output register.
// ============================================================================
module tpid_dp
  import tpid_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [TIME_BITS-1:0]          in_stamp,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_drive,
  output logic                          out_status
);

  localparam int BMAX = (TIME_BITS > GAIN_BITS) ? TIME_BITS : GAIN_BITS;
  localparam int MB   = ((BMAX + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;

  logic signed [GAIN_BITS-1:0]   gain_p_r, gain_i_r, gain_d_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic [TIME_BITS-1:0]          stamp_r;
  logic [TIME_BITS-1:0]          gap_r;
  logic signed [SAMPLE_BITS-1:0] held_sample_r;
  logic [TIME_BITS-1:0]          held_stamp_r;
  logic                          held_valid_r;
  logic signed [ACC_BITS-1:0]    isum_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic                          status_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_drive_r;
  logic                          out_status_r;

  logic [SAMPLE_BITS:0]          pair_sum;
  logic [SAMPLE_BITS:0]          pair_diff;
  logic signed [ACC_BITS-1:0]    a_sv;
  logic [MB:0]                   b_sv;
  logic [ACC_BITS-1:0]           a_mag;
  logic [MB:0]                   b_abs;
  logic                          mul_neg;
  logic                          mul_frac;
  logic                          mul_done;
  logic signed [ACC_BITS-1:0]    mul_res;
  logic                          div_done;
  logic signed [ACC_BITS-1:0]    div_res;
  logic [ACC_BITS-SAMPLE_BITS:0] acc_top;
  logic signed [SAMPLE_BITS-1:0] drive_sat;
  logic signed [ACC_BITS-1:0]    acc_nxt;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] x,
    input logic signed [ACC_BITS-1:0] y
  );
    logic [ACC_BITS:0] s;
    s = {x[ACC_BITS-1], x} + {y[ACC_BITS-1], y};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  // Operand selection for the shared multiplier; gap and gains go on the
  // digit-serial side.
  always_comb begin
    pair_sum  = {cur_r[SAMPLE_BITS-1], cur_r} + {held_sample_r[SAMPLE_BITS-1], held_sample_r};
    pair_diff = {cur_r[SAMPLE_BITS-1], cur_r} - {held_sample_r[SAMPLE_BITS-1], held_sample_r};
    unique case (cmd.mul_sel)
      MSEL_P: begin
        a_sv = {{(ACC_BITS-SAMPLE_BITS){cur_r[SAMPLE_BITS-1]}}, cur_r};
        b_sv = {{(MB+1-GAIN_BITS){gain_p_r[GAIN_BITS-1]}}, gain_p_r};
      end
      MSEL_INC: begin
        a_sv = {{(ACC_BITS-SAMPLE_BITS-1){pair_sum[SAMPLE_BITS]}}, pair_sum};
        b_sv = {{(MB+1-TIME_BITS){1'b0}}, gap_r};
      end
      MSEL_ITERM: begin
        a_sv = isum_r;
        b_sv = {{(MB+1-GAIN_BITS){gain_i_r[GAIN_BITS-1]}}, gain_i_r};
      end
      MSEL_DTERM: begin
        a_sv = {{(ACC_BITS-SAMPLE_BITS-1){pair_diff[SAMPLE_BITS]}}, pair_diff};
        b_sv = {{(MB+1-GAIN_BITS){gain_d_r[GAIN_BITS-1]}}, gain_d_r};
      end
      default: begin
        a_sv = '0;
        b_sv = '0;
      end
    endcase
    a_mag    = a_sv[ACC_BITS-1] ? (~a_sv + 1'b1) : a_sv;
    b_abs    = b_sv[MB] ? (~b_sv + 1'b1) : b_sv;
    mul_neg  = a_sv[ACC_BITS-1] ^ b_sv[MB];
    mul_frac = (cmd.mul_sel != MSEL_INC);
  end

  tpid_mul #(
    .B_BITS (MB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (a_mag),
    .b_mag (b_abs[MB-1:0]),
    .neg   (mul_neg),
    .frac  (mul_frac),
    .done  (mul_done),
    .res   (mul_res)
  );

  tpid_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (mul_res),
    .den   (gap_r),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD_MUL: acc_nxt = mul_res;
      ACC_ADD_MUL:  acc_nxt = sat_add(acc_r, mul_res);
      ACC_ADD_DIV:  acc_nxt = sat_add(acc_r, div_res);
      default:      acc_nxt = acc_r;
    endcase
    acc_top = acc_r[ACC_BITS-1:SAMPLE_BITS-1];
    if (&acc_top || ~|acc_top) begin
      drive_sat = acc_r[SAMPLE_BITS-1:0];
    end else begin
      drive_sat = acc_r[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      held_sample_r <= '0;
      held_stamp_r  <= '0;
      held_valid_r  <= 1'b0;
      isum_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P: gain_p_r <= cfg_wdata;
          REG_GAIN_I: gain_i_r <= cfg_wdata;
          REG_GAIN_D: gain_d_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        held_sample_r <= '0;
        held_stamp_r  <= '0;
        held_valid_r  <= 1'b0;
        isum_r        <= '0;
      end else begin
        if (cmd.finish) begin
          held_sample_r <= cur_r;
          held_stamp_r  <= stamp_r;
          held_valid_r  <= 1'b1;
        end
        if (cmd.isum_add) begin
          isum_r <= sat_add(isum_r, mul_res);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r    <= in_sample;
      stamp_r  <= in_stamp;
      gap_r    <= in_stamp - held_stamp_r;
      status_r <= 1'b0;
    end else if (cmd.set_status) begin
      status_r <= 1'b1;
    end
    acc_r <= acc_nxt;
    if (cmd.finish) begin
      out_drive_r  <= drive_sat;
      out_status_r <= status_r;
    end
  end

  always_comb begin
    sts.mul_done   = mul_done;
    sts.div_done   = div_done;
    sts.held_valid = held_valid_r;
    sts.gap_zero   = (gap_r == '0);
    sts.gain_i_nz  = (gain_i_r != '0);
    sts.gain_d_nz  = (gain_d_r != '0);
    sts.diff_nz    = (cur_r != held_sample_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_drive  = out_drive_r;
  assign out_status = out_status_r;

endmodule

// File: rtl/core/tpid_ctrl.sv
// ============================================================================
// tpid_ctrl
// Sequencer of the PID controller: takes an item; for a clear it drops the
// held sample and the integral sum, for a sample it runs the proportional,
// integral and derivative steps on the shared units and hands the result to the output register.
// ============================================================================
module tpid_ctrl
  import tpid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_GO,
    ST_P_WAIT,
    ST_INC_GO,
    ST_INC_WAIT,
    ST_I_GO,
    ST_I_WAIT,
    ST_D_GO,
    ST_D_WAIT,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_P_GO;
          end
        end
      end
      ST_P_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_P;
        state_nxt     = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_op = ACC_LOAD_MUL;
          if (!sts.held_valid) begin
            state_nxt = ST_FINISH;
          end else if (sts.gap_zero) begin
            // Same timestamp: only the proportional term, flagged when the
            // value jumped while the derivative is enabled.
            cmd.set_status = sts.gain_d_nz && sts.diff_nz;
            state_nxt      = ST_FINISH;
          end else if (sts.gain_i_nz) begin
            state_nxt = ST_INC_GO;
          end else if (sts.gain_d_nz) begin
            state_nxt = ST_D_GO;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_INC_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_INC;
        state_nxt     = ST_INC_WAIT;
      end
      ST_INC_WAIT: begin
        if (sts.mul_done) begin
          cmd.isum_add = 1'b1;
          state_nxt    = ST_I_GO;
        end
      end
      ST_I_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_ITERM;
        state_nxt     = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc_op = ACC_ADD_MUL;
          state_nxt  = sts.gain_d_nz ? ST_D_GO : ST_FINISH;
        end
      end
      ST_D_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_DTERM;
        state_nxt     = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.acc_op = ACC_ADD_DIV;
          state_nxt  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// File: tb/tb_timestamped_pid_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_pid_controller_core
// Self-checking bench for the event-driven PID core. A short directed list
// walks the field extremes, zero and wrapped time gaps, clears and extreme
// gains. Random phases with fresh gains then follow. Each accepted sample
// is run through a bit-exact fixed-point predictor, and every result beat
// is checked against the oldest predicted drive and status.
// ----------------------------------------------------------------------------
module tb_timestamped_pid_controller_core;
  import tpid_pkg::*;

  localparam int SAMPLE_W      = 32;
  localparam int TIME_W        = 32;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_EVENTS  = 112;
  localparam int PRINT_CAP     = 40;

  localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          stamp;
  } pid_event_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       status;
  } pid_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  tpid_in_if  #(.SAMPLE_BITS(SAMPLE_W), .TIME_BITS(TIME_W)) in_ch ();
  tpid_out_if #(.SAMPLE_BITS(SAMPLE_W))                     out_ch ();

  timestamped_pid_controller_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .TIME_BITS  (TIME_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pid_event_t  pending_events[$];
  pid_result_t expected_drives[$];
  pid_event_t  next_event;
  pid_result_t got_drive;
  pid_result_t want_drive;
  logic        in_beat_taken;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int samples_sent;
  int clears_sent;
  int results_checked;
  int gain_sets;
  int cycle_count;

  // Predictor state: gains and the controller's memory.
  longint            kp, ki, kd;
  longint            last_sample;
  logic [TIME_W-1:0] last_stamp;
  bit                last_valid;
  longint            isum;

  // Stimulus bookkeeping.
  logic [TIME_W-1:0]          stamp_now;
  logic signed [SAMPLE_W-1:0] sample_prev;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a * b / 2^sh), saturated to the accumulator width.
  function automatic longint qmul_floor(input longint a, input longint b,
                                        input int unsigned sh);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> sh;
    if (prod > ACC_MAX) return ACC_MAX;
    if (prod < ACC_MIN) return ACC_MIN;
    return prod[63:0];
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic signed [64:0] wa, wb, s;
    wa = a;
    wb = b;
    s = wa + wb;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s[63:0];
  endfunction

  // Advances the controller state by one event; returns 1 when it yields a result.
  function automatic bit predict_drive(input pid_event_t ev, output pid_result_t res);
    longint            cur, acc, inc, num, gap_l;
    logic [TIME_W-1:0] gap;
    res = '0;
    if (ev.op == OP_CLEAR) begin
      last_sample = 0;
      last_stamp  = '0;
      last_valid  = 1'b0;
      isum        = 0;
      return 1'b0;
    end
    cur = ev.sample;
    acc = qmul_floor(kp, cur, Q_FRAC);
    if (last_valid) begin
      gap = ev.stamp - last_stamp;
      gap_l = gap;
      if (gap == '0) begin
        if (kd != 0 && cur != last_sample) res.status = 1'b1;
      end else begin
        if (ki != 0) begin
          inc  = qmul_floor(cur + last_sample, gap_l, 1);
          isum = add_sat(isum, inc);
          acc  = add_sat(acc, qmul_floor(isum, ki, Q_FRAC));
        end
        if (kd != 0) begin
          num = qmul_floor(kd, cur - last_sample, Q_FRAC);
          acc = add_sat(acc, num / gap_l);
        end
      end
    end
    last_sample = cur;
    last_stamp  = ev.stamp;
    last_valid  = 1'b1;
    if (acc > Q_MAX) acc = Q_MAX;
    if (acc < Q_MIN) acc = Q_MIN;
    res.drive = acc[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_gain(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic signed [SAMPLE_W-1:0] p,
                           input logic signed [SAMPLE_W-1:0] i,
                           input logic signed [SAMPLE_W-1:0] d);
    write_gain(REG_GAIN_P, p);
    write_gain(REG_GAIN_I, i);
    write_gain(REG_GAIN_D, d);
    gain_sets++;
  endtask

  // A clear beat gives no result, so the core may still be busy with it when
  // the last expected beat has arrived; the extra pause covers that.
  task automatic wait_quiet();
    while (pending_events.size() != 0 || in_ch.valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_event(input op_t op, input logic signed [SAMPLE_W-1:0] s,
                                    input logic [TIME_W-1:0] t);
    pid_event_t ev;
    ev.op     = op;
    ev.sample = s;
    ev.stamp  = t;
    pending_events.push_back(ev);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return $urandom;
      default: return $urandom_range(0, 2 ** 19) - 2 ** 18;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return $urandom;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return '0;
      default: return $urandom_range(0, 2 ** 22) - 2 ** 21;
    endcase
  endfunction

  // Mostly a plausible event stream: small forward steps in time with values
  // near zero. Zero gaps, huge or wrapping gaps and clears are mixed in.
  task automatic queue_random_events(input int n);
    logic [TIME_W-1:0]          gap;
    logic signed [SAMPLE_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(31) == 0) begin
        add_event(OP_CLEAR, $urandom, $urandom);
      end else begin
        case ($urandom_range(19))
          0:       gap = '0;
          1:       gap = $urandom;
          2:       gap = $urandom_range(1000, 100000);
          default: gap = $urandom_range(1, 32);
        endcase
        s = (gap == '0 && $urandom_range(1) == 0) ? sample_prev : pick_sample();
        stamp_now   = stamp_now + gap;
        sample_prev = s;
        add_event(OP_SAMPLE, s, stamp_now);
      end
    end
  endtask

  // Sender: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_taken) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_event = pending_events.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.op     <= next_event.op;
        in_ch.sample <= next_event.sample;
        in_ch.stamp  <= next_event.stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    in_beat_taken = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_beat_taken = 1'b1;
      next_event.op     = op_t'(in_ch.op);
      next_event.sample = in_ch.sample;
      next_event.stamp  = in_ch.stamp;
      if (next_event.op == OP_CLEAR) clears_sent++;
      else samples_sent++;
      if (predict_drive(next_event, want_drive)) expected_drives.push_back(want_drive);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_drive.drive  = out_ch.drive;
      got_drive.status = out_ch.status;
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (drive %h)",
                                  got_drive.drive));
      end else begin
        want_drive = expected_drives.pop_front();
        if (got_drive.drive !== want_drive.drive)
          report_mismatch($sformatf("drive %h, expected %h", got_drive.drive,
                                    want_drive.drive));
        if (got_drive.status !== want_drive.status)
          report_mismatch($sformatf("status %b, expected %b", got_drive.status,
                                    want_drive.status));
        results_checked++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
             expected_drives.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_GAIN_P;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_SAMPLE;
    in_ch.sample  = '0;
    in_ch.stamp   = '0;
    out_ch.ready  = 1'b0;
    in_beat_taken = 1'b0;
    kp = 0;
    ki = 0;
    kd = 0;
    last_sample = 0;
    last_stamp  = '0;
    last_valid  = 1'b0;
    isum        = 0;
    stamp_now   = '0;
    sample_prev = '0;
    mismatch_count  = 0;
    samples_sent    = 0;
    clears_sent     = 0;
    results_checked = 0;
    gain_sets       = 0;
    send_idle_pct   = 34;
    recv_idle_pct   = 46;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Moderate gains: first sample, zero gaps with equal and differing values,
    // a one-tick gap, a full-range gap, a stamp running backwards and a clear.
    set_gains(Q_ONE, 32'sh0000_8000, 32'sh0002_0000);
    add_event(OP_SAMPLE, Q_MAX, 32'h0000_0000);
    add_event(OP_SAMPLE, Q_MAX, 32'h0000_0000);
    add_event(OP_SAMPLE, Q_MIN, 32'h0000_0000);
    add_event(OP_SAMPLE, Q_MIN, 32'h0000_0001);
    add_event(OP_SAMPLE, Q_MAX, 32'hFFFF_FFFF);
    add_event(OP_SAMPLE, '0,    32'h0000_0003);
    add_event(OP_CLEAR,  Q_MAX, 32'hFFFF_FFFF);
    add_event(OP_SAMPLE, -32'sd1, 32'hFFFF_FFFF);
    add_event(OP_SAMPLE, 32'sd1,  32'h0000_0000);
    wait_quiet();

    // Extreme gains drive the results into saturation.
    set_gains(Q_MAX, Q_MIN, Q_MAX);
    add_event(OP_SAMPLE, Q_MAX, 32'd100);
    add_event(OP_SAMPLE, Q_MIN, 32'd101);
    add_event(OP_SAMPLE, Q_MAX, 32'd101);
    add_event(OP_SAMPLE, Q_MIN, 32'h8000_0101);
    add_event(OP_CLEAR,  '0,    '0);
    add_event(OP_SAMPLE, Q_MIN, 32'd7);
    wait_quiet();

    // Integral and derivative off: a changed value at zero gap stays ok.
    set_gains(Q_MIN, '0, '0);
    add_event(OP_SAMPLE, Q_MIN, 32'd0);
    add_event(OP_SAMPLE, Q_MAX, 32'd0);
    add_event(OP_SAMPLE, 32'sh0001_2345, 32'd50);
    add_event(OP_CLEAR,  '0, '0);
    add_event(OP_CLEAR,  '0, '0);
    add_event(OP_SAMPLE, Q_MAX, 32'd60);
    add_event(OP_SAMPLE, Q_MIN, 32'd61);
    stamp_now = 32'd61;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();
      if (ph == RAND_PHASES / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 34;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_gains(pick_gain(), pick_gain(), pick_gain());
      queue_random_events(PHASE_EVENTS);
    end
    wait_quiet();

    $display("Checked %0d result beats from %0d samples and %0d clears", results_checked,
             samples_sent, clears_sent);
    $display("across %0d gain settings and three stall patterns, %0d mismatches.",
             gain_sets, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tpid_pkg.sv
rtl/core/tpid_in_if.sv
rtl/core/tpid_out_if.sv
rtl/core/tpid_mul.sv
rtl/core/tpid_div.sv
rtl/core/tpid_dp.sv
rtl/core/tpid_ctrl.sv
rtl/core/timestamped_pid_controller_core.sv
tb/tb_timestamped_pid_controller_core.sv
